@@ hdl/hct_pkg.sv @@
`timescale 1ns / 1ps

package hct_pkg;

  localparam int NumSlots = 256;
  localparam int SlotW    = $clog2(NumSlots);
  localparam int PinW     = 12;
  localparam int RefW     = 14;
  localparam int LiveW    = $clog2(NumSlots + 1);
  localparam int GrpSize  = 16;
  localparam int NumGrps  = NumSlots / GrpSize;
  localparam int GrpW     = $clog2(GrpSize);
  localparam int GrpSelW  = $clog2(NumGrps);

  typedef enum logic [3:0] {
    ACT_CREATE     = 4'd0,
    ACT_REGISTER   = 4'd1,
    ACT_UNPEND     = 4'd2,
    ACT_REMOVE     = 4'd3,
    ACT_PIN        = 4'd4,
    ACT_PIN_REF    = 4'd5,
    ACT_PIN_DELETE = 4'd6,
    ACT_DROP_CHILD = 4'd7,
    ACT_REPIN      = 4'd8,
    ACT_UNPIN      = 4'd9,
    ACT_ADD_REF    = 4'd10,
    ACT_DROP_REF   = 4'd11,
    ACT_UNPIN_DROP = 4'd12,
    ACT_CLOSE      = 4'd13,
    ACT_QUERY      = 4'd14
  } action_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NORES   = 3'd1,
    ST_BADPAR  = 3'd2,
    ST_DELETED = 3'd3,
    ST_ILLEGAL = 3'd4,
    ST_AGAIN   = 3'd5
  } status_e;

  typedef struct packed {
    logic [3:0]       action;
    logic [SlotW-1:0] slot;
    logic             implicit_entity;
    logic             children_counted;
    logic             user_allowed;
    logic             user_request;
    logic             explicit_delete;
    logic             parent_deletable;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [SlotW-1:0] handle_out;
    logic             answer;
    logic             wake_closer;
    logic [PinW-1:0]  pin_count_out;
    logic [RefW-1:0]  ref_count_out;
    logic [2:0]       flags_out;
  } rsp_t;

  typedef struct packed {
    logic no_user;
    logic children;
    logic impl;
    logic deferred;
    logic closing;
    logic pending;
  } flags_t;

  typedef struct packed {
    logic [PinW-1:0] pin;
    logic [RefW-1:0] refc;
    flags_t          flags;
  } ent_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [SlotW-1:0] slot;
  } slot_upd_t;

  typedef struct packed {
    req_t             req;
    ent_t             ent;
    logic             slot_valid;
    logic             live_full;
    logic             free_found;
    logic [SlotW-1:0] free_idx;
  } act_in_t;

  typedef struct packed {
    rsp_t             rsp;
    logic             wr_en;
    logic [SlotW-1:0] wr_slot;
    ent_t             wr_ent;
    slot_upd_t        upd;
  } act_out_t;

endpackage

@@ hdl/hct_entry_mem.sv @@
`timescale 1ns / 1ps

module hct_entry_mem (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [hct_pkg::SlotW-1:0]  rd_addr_i,
  output hct_pkg::ent_t              rd_data_o,
  input  logic                       wr_en_i,
  input  logic [hct_pkg::SlotW-1:0]  wr_addr_i,
  input  hct_pkg::ent_t              wr_data_i
);

  hct_pkg::ent_t mem_q [hct_pkg::NumSlots];
  hct_pkg::ent_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/hct_slot_map.sv @@
`timescale 1ns / 1ps

module hct_slot_map (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cap_i,
  input  hct_pkg::slot_upd_t         upd_i,
  input  logic [hct_pkg::SlotW-1:0]  rd_slot_i,
  output logic                       slot_valid_o,
  output logic                       live_full_o,
  output logic                       free_found_o,
  output logic [hct_pkg::SlotW-1:0]  free_idx_o
);

  logic [hct_pkg::NumSlots-1:0] valid_q;
  logic [hct_pkg::LiveW-1:0]    live_q;
  logic [hct_pkg::NumGrps-1:0]  grp_free_q, grp_free_d;
  logic [hct_pkg::GrpW-1:0]     grp_idx_q [hct_pkg::NumGrps];
  logic [hct_pkg::GrpW-1:0]     grp_idx_d [hct_pkg::NumGrps];
  logic [hct_pkg::GrpSelW-1:0]  grp_sel;

  // stage 1: lowest free slot inside each group
  always_comb begin
    for (int g = 0; g < hct_pkg::NumGrps; g++) begin
      grp_free_d[g] = 1'b0;
      grp_idx_d[g]  = '0;
      for (int j = hct_pkg::GrpSize - 1; j >= 0; j--) begin
        if (!valid_q[g * hct_pkg::GrpSize + j]) begin
          grp_free_d[g] = 1'b1;
          grp_idx_d[g]  = hct_pkg::GrpW'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      grp_free_q <= grp_free_d;
      grp_idx_q  <= grp_idx_d;
    end
  end

  // stage 2: lowest group with a free slot
  always_comb begin
    grp_sel = '0;
    for (int g = hct_pkg::NumGrps - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        grp_sel = hct_pkg::GrpSelW'(g);
      end
    end
  end

  assign free_found_o = |grp_free_q;
  assign free_idx_o   = {grp_sel, grp_idx_q[grp_sel]};
  assign slot_valid_o = valid_q[rd_slot_i];
  assign live_full_o  = live_q >= hct_pkg::LiveW'(hct_pkg::NumSlots);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      live_q  <= '0;
    end else begin
      if (upd_i.set) begin
        valid_q[upd_i.slot] <= 1'b1;
        live_q              <= live_q + 1'b1;
      end else if (upd_i.clr) begin
        valid_q[upd_i.slot] <= 1'b0;
        if (live_q != '0) begin
          live_q <= live_q - 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_live_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(live_q))
    else $error("live count out of step with valid map");

  a_set_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i.set |-> !valid_q[upd_i.slot])
    else $error("allocating an occupied slot");
`endif

endmodule

@@ hdl/hct_action.sv @@
`timescale 1ns / 1ps

module hct_action (
  input  hct_pkg::act_in_t  act_i,
  output hct_pkg::act_out_t act_o
);

  function automatic hct_pkg::ent_t drop_one_ref(hct_pkg::ent_t x);
    hct_pkg::ent_t r;
    r = x;
    if (x.refc == hct_pkg::RefW'(1)) begin
      r.refc          = '0;
      r.pin           = x.pin + 1'b1;
      r.flags.closing = 1'b1;
    end else if (!x.flags.children) begin
      r.refc           = x.refc - 1'b1;
      r.flags.deferred = 1'b1;
    end else begin
      r.refc = x.refc - 1'b1;
    end
    return r;
  endfunction

  hct_pkg::req_t    req;
  hct_pkg::ent_t    e;
  hct_pkg::ent_t    ini;
  hct_pkg::ent_t    shown;
  hct_pkg::action_e act;
  hct_pkg::status_e st;
  logic             answer;
  logic             wake;
  logic             show;

  assign req = act_i.req;
  assign act = hct_pkg::action_e'(req.action);

  always_comb begin
    ini               = '0;
    ini.pin           = hct_pkg::PinW'(1);
    ini.refc          = req.implicit_entity ? '0 : hct_pkg::RefW'(1);
    ini.flags.pending = 1'b1;
    ini.flags.impl    = req.implicit_entity;
    ini.flags.children = req.children_counted;
    ini.flags.no_user = (act == hct_pkg::ACT_CREATE) ? !req.user_allowed : 1'b0;

    e      = act_i.ent;
    st     = hct_pkg::ST_OK;
    answer = 1'b0;
    wake   = 1'b0;
    show   = 1'b0;
    shown  = '0;
    act_o  = '0;
    act_o.rsp.handle_out = req.slot;

    if (act == hct_pkg::ACT_CREATE) begin
      if (act_i.live_full || !act_i.free_found) begin
        st = hct_pkg::ST_NORES;
        act_o.rsp.handle_out = '0;
      end else begin
        act_o.wr_en   = 1'b1;
        act_o.wr_slot = act_i.free_idx;
        act_o.wr_ent  = ini;
        act_o.upd.set  = 1'b1;
        act_o.upd.slot = act_i.free_idx;
        act_o.rsp.handle_out = act_i.free_idx;
        shown = ini;
        show  = 1'b1;
      end
    end else if (act == hct_pkg::ACT_REGISTER) begin
      if (act_i.live_full) begin
        st = hct_pkg::ST_NORES;
      end else if (act_i.slot_valid) begin
        st    = hct_pkg::ST_BADPAR;
        shown = e;
        show  = 1'b1;
      end else begin
        act_o.wr_en   = 1'b1;
        act_o.wr_slot = req.slot;
        act_o.wr_ent  = ini;
        act_o.upd.set  = 1'b1;
        act_o.upd.slot = req.slot;
        shown = ini;
        show  = 1'b1;
      end
    end else if (!act_i.slot_valid || req.action > hct_pkg::ACT_QUERY) begin
      st = hct_pkg::ST_BADPAR;
    end else begin
      unique case (act)
        hct_pkg::ACT_UNPEND: begin
          e.flags.pending = 1'b0;
          e.pin = e.pin - 1'b1;
          wake = e.flags.closing && e.pin == hct_pkg::PinW'(1);
        end
        hct_pkg::ACT_REMOVE: begin
          act_o.upd.clr  = 1'b1;
          act_o.upd.slot = req.slot;
        end
        hct_pkg::ACT_PIN, hct_pkg::ACT_PIN_REF: begin
          if (e.flags.closing || e.flags.pending || (e.flags.no_user && req.user_request)) begin
            st = hct_pkg::ST_BADPAR;
          end else begin
            e.pin = e.pin + 1'b1;
            if (act == hct_pkg::ACT_PIN_REF) begin
              e.refc = e.refc + 1'b1;
            end
          end
        end
        hct_pkg::ACT_PIN_DELETE: begin
          if ((req.user_request && e.flags.no_user) || e.flags.closing || e.flags.pending) begin
            st = hct_pkg::ST_BADPAR;
          end else if (e.flags.deferred) begin
            if (e.refc != '0) begin
              st = hct_pkg::ST_DELETED;
            end else begin
              e.pin = e.pin + 1'b1;
              e.flags.closing = 1'b1;
            end
          end else if (req.explicit_delete) begin
            if (e.flags.impl) begin
              e.pin = e.pin + 1'b1;
              e.flags.closing = 1'b1;
            end else if (e.refc == hct_pkg::RefW'(1) || e.flags.children) begin
              e.refc = e.refc - 1'b1;
              e.pin  = e.pin + 1'b1;
              e.flags.closing = 1'b1;
            end else begin
              e = drop_one_ref(e);
            end
          end else if (!e.flags.impl) begin
            st = hct_pkg::ST_ILLEGAL;
          end else begin
            e = drop_one_ref(e);
          end
          if (st == hct_pkg::ST_OK && e.refc != '0 && !e.flags.children) begin
            st = hct_pkg::ST_AGAIN;
          end
        end
        hct_pkg::ACT_DROP_CHILD: begin
          if (!e.flags.closing && !e.flags.pending && e.flags.impl &&
              e.refc == hct_pkg::RefW'(1) && req.parent_deletable) begin
            e.refc = '0;
            e.pin  = e.pin + 1'b1;
            answer = 1'b1;
          end else begin
            e.refc = e.refc - 1'b1;
          end
        end
        hct_pkg::ACT_REPIN: begin
          e.pin = e.pin + 1'b1;
        end
        hct_pkg::ACT_UNPIN: begin
          e.pin = e.pin - 1'b1;
          wake = e.flags.closing && e.pin == hct_pkg::PinW'(1);
        end
        hct_pkg::ACT_ADD_REF: begin
          e.refc = e.refc + 1'b1;
        end
        hct_pkg::ACT_DROP_REF: begin
          e.refc = e.refc - 1'b1;
          wake   = e.flags.closing && e.pin == hct_pkg::PinW'(1);
          answer = e.refc == '0;
        end
        hct_pkg::ACT_UNPIN_DROP: begin
          e.refc = e.refc - 1'b1;
          e.pin  = e.pin - 1'b1;
          wake   = e.flags.closing && e.pin == hct_pkg::PinW'(1);
          answer = e.refc == '0;
        end
        hct_pkg::ACT_CLOSE: begin
          answer = e.refc == '0;
          e.flags.closing = 1'b1;
        end
        default: begin
          answer = e.refc == '0;
        end
      endcase
      act_o.wr_en   = act != hct_pkg::ACT_REMOVE;
      act_o.wr_slot = req.slot;
      act_o.wr_ent  = e;
      shown = e;
      show  = 1'b1;
    end

    act_o.rsp.status      = st;
    act_o.rsp.answer      = answer;
    act_o.rsp.wake_closer = wake;
    if (show) begin
      act_o.rsp.pin_count_out = shown.pin;
      act_o.rsp.ref_count_out = shown.refc;
      act_o.rsp.flags_out = {shown.flags.deferred, shown.flags.closing, shown.flags.pending};
    end
  end

endmodule

@@ hdl/handle_table_refcount_lifecycle.sv @@
`timescale 1ns / 1ps

// Handle table with reference and pin counting.
// Command channel: a word on req_i is taken at a rising edge where start_i is
// high and busy_o is low. busy_o is high for one cycle after each accepted
// command.
// Result channel: done_o is high for exactly one cycle and marks the result
// word on rsp_o; the receiver cannot stall. rsp_o keeps the word until a
// later result replaces it. Sequence: the entry memory is read at the
// accepting edge, which enters S_EXEC; there the entry is modified, and the
// edge that leaves S_EXEC writes it back, registers the result and raises done_o.
// busy_o holds off a new command while the single read-modify-write of the
// entry memory is in S_EXEC; a new command may be accepted in the cycle its
// predecessor's result is shown.
// create takes the lowest free slot; the free-slot search is a two-level
// registered tree sampled when the command is accepted.
// Reset: all slots free, live count zero, no result pending. Entry contents
// are not cleared; an entry is only used after create or register wrote it.
module handle_table_refcount_lifecycle (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  hct_pkg::req_t req_i,
  output logic          done_o,
  output hct_pkg::rsp_t rsp_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e            state_q;
  hct_pkg::req_t     req_q;
  hct_pkg::rsp_t     rsp_q;
  logic              done_q;
  logic              accept;
  hct_pkg::ent_t     rd_ent;
  hct_pkg::act_in_t  act_in;
  hct_pkg::act_out_t act_out;
  logic              slot_valid;
  logic              live_full;
  logic              free_found;
  logic [hct_pkg::SlotW-1:0] free_idx;
  hct_pkg::slot_upd_t upd;

  assign busy_o = state_q != S_IDLE;
  assign accept = start_i && !busy_o;

  hct_entry_mem u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (req_i.slot),
    .rd_data_o (rd_ent),
    .wr_en_i   (act_out.wr_en && state_q == S_EXEC),
    .wr_addr_i (act_out.wr_slot),
    .wr_data_i (act_out.wr_ent)
  );

  always_comb begin
    upd = act_out.upd;
    if (state_q != S_EXEC) begin
      upd.set = 1'b0;
      upd.clr = 1'b0;
    end
  end

  hct_slot_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (accept),
    .upd_i        (upd),
    .rd_slot_i    (req_q.slot),
    .slot_valid_o (slot_valid),
    .live_full_o  (live_full),
    .free_found_o (free_found),
    .free_idx_o   (free_idx)
  );

  always_comb begin
    act_in.req        = req_q;
    act_in.ent        = rd_ent;
    act_in.slot_valid = slot_valid;
    act_in.live_full  = live_full;
    act_in.free_found = free_found;
    act_in.free_idx   = free_idx;
  end

  hct_action u_act (
    .act_i (act_in),
    .act_o (act_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      req_q   <= '0;
      rsp_q   <= '0;
    end else begin
      done_q <= state_q == S_EXEC;
      if (accept) begin
        req_q <= req_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          rsp_q   <= act_out.rsp;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef ASSERT_OFF
  a_accept_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted word did not enter execution");

  a_exec_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> done_o && !busy_o)
    else $error("execution did not produce a result");

  a_done_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_EXEC))
    else $error("result without execution");

  a_write_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd.set || upd.clr) |-> state_q == S_EXEC)
    else $error("slot map update outside execution");
`endif

endmodule

@@ tb/sv/handle_table_refcount_lifecycle_test.sv @@
`timescale 1ns / 1ps

module handle_table_refcount_lifecycle_test;
  import hct_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int ReqW = $bits(req_t);
  localparam logic [3:0] ActUnused = 4'hF;
  localparam logic [PinW-1:0] PinOne = 1;
  localparam logic [RefW-1:0] RefOne = 1;
  localparam logic [2:0] FlPending = 3'b001;

  // option bits in word order: implicit, children, user access, from user,
  // explicit delete, may delete parent
  localparam logic [5:0] OptNone     = 6'b000000;
  localparam logic [5:0] OptImpl     = 6'b100000;
  localparam logic [5:0] OptChild    = 6'b010000;
  localparam logic [5:0] OptUser     = 6'b001000;
  localparam logic [5:0] OptFromUser = 6'b000100;
  localparam logic [5:0] OptExpl     = 6'b000010;
  localparam logic [5:0] OptMayDel   = 6'b000001;

  typedef struct {
    req_t word;
    bit   fixed;
    rsp_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  ent_t        slot_ent [NumSlots];
  bit          slot_used [NumSlots];
  int unsigned live_slots = 0;
  int unsigned peak_live = 0;

  rsp_t        results_due [$];
  plan_row_t   plan_rows [$];
  int unsigned idle_pct = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned bad_count = 0;
  int unsigned cycle_count = 0;
  int unsigned status_seen [8];

  handle_table_refcount_lifecycle u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic req_t cmd(logic [3:0] act, logic [SlotW-1:0] slot, logic [5:0] opt);
    return {act, slot, opt};
  endfunction

  function automatic rsp_t rsp_of(status_e st, logic [SlotW-1:0] h, logic [PinW-1:0] pin,
                                  logic [RefW-1:0] rc, logic [2:0] fl);
    rsp_t r;
    r = '0;
    r.status = st;
    r.handle_out = h;
    r.pin_count_out = pin;
    r.ref_count_out = rc;
    r.flags_out = fl;
    return r;
  endfunction

  function automatic void plan(req_t w, bit fixed = 1'b0, rsp_t want = '0);
    plan_row_t row;
    row.word = w;
    row.fixed = fixed;
    row.want = want;
    plan_rows.push_back(row);
  endfunction

  function automatic ent_t fresh_entry(logic impl, logic children, logic user);
    ent_t e;
    e = '0;
    e.pin = PinOne;
    e.refc = impl ? '0 : RefOne;
    e.flags.pending = 1'b1;
    e.flags.impl = impl;
    e.flags.children = children;
    e.flags.no_user = !user;
    return e;
  endfunction

  function automatic logic wakes(ent_t e);
    return e.flags.closing && e.pin == PinOne;
  endfunction

  function automatic status_e pin_plain(inout ent_t e, input logic user_request,
                                        input logic add_ref);
    if (e.flags.closing || e.flags.pending) return ST_BADPAR;
    if (e.flags.no_user && user_request) return ST_BADPAR;
    e.pin = e.pin + PinOne;
    e.refc = e.refc + RefW'(add_ref);
    return ST_OK;
  endfunction

  function automatic void drop_one_ref(inout ent_t e);
    if (e.refc == RefOne) begin
      e.refc = '0;
      e.pin = e.pin + PinOne;
      e.flags.closing = 1'b1;
    end else begin
      e.refc = e.refc - RefOne;
      if (!e.flags.children) e.flags.deferred = 1'b1;
    end
  endfunction

  function automatic status_e pin_for_delete(inout ent_t e, input logic user_request,
                                             input logic expl);
    flags_t f;
    f = e.flags;
    if (user_request && f.no_user) return ST_BADPAR;
    if (f.closing || f.pending) return ST_BADPAR;
    if (f.deferred) begin
      if (e.refc != '0) return ST_DELETED;
      e.pin = e.pin + PinOne;
      e.flags.closing = 1'b1;
    end else if (expl) begin
      if (f.impl) begin
        e.pin = e.pin + PinOne;
        e.flags.closing = 1'b1;
      end else if (e.refc == RefOne || f.children) begin
        e.refc = e.refc - RefOne;
        e.pin = e.pin + PinOne;
        e.flags.closing = 1'b1;
      end else begin
        drop_one_ref(e);
      end
    end else begin
      if (!f.impl) return ST_ILLEGAL;
      drop_one_ref(e);
    end
    return (e.refc == '0 || e.flags.children) ? ST_OK : ST_AGAIN;
  endfunction

  function automatic rsp_t apply_action(req_t w);
    rsp_t r;
    ent_t e;
    int unsigned idx;
    r = '0;
    r.status = ST_OK;
    r.handle_out = w.slot;
    e = '0;
    if (w.action == ACT_CREATE) begin
      idx = 0;
      while (idx < NumSlots && slot_used[idx]) idx++;
      if (live_slots >= NumSlots || idx >= NumSlots) begin
        r.status = ST_NORES;
        r.handle_out = '0;
      end else begin
        e = fresh_entry(w.implicit_entity, w.children_counted, w.user_allowed);
        slot_ent[idx] = e;
        slot_used[idx] = 1'b1;
        live_slots++;
        r.handle_out = SlotW'(idx);
      end
    end else if (w.action == ACT_REGISTER) begin
      if (live_slots >= NumSlots) begin
        r.status = ST_NORES;
      end else if (slot_used[w.slot]) begin
        r.status = ST_BADPAR;
        e = slot_ent[w.slot];
      end else begin
        e = fresh_entry(w.implicit_entity, w.children_counted, 1'b1);
        slot_ent[w.slot] = e;
        slot_used[w.slot] = 1'b1;
        live_slots++;
      end
    end else if (w.action == ActUnused || !slot_used[w.slot]) begin
      r.status = ST_BADPAR;
    end else begin
      e = slot_ent[w.slot];
      case (w.action)
        ACT_UNPEND: begin
          e.flags.pending = 1'b0;
          e.pin = e.pin - PinOne;
          r.wake_closer = wakes(e);
        end
        ACT_REMOVE: begin
          slot_used[w.slot] = 1'b0;
          if (live_slots > 0) live_slots--;
        end
        ACT_PIN:        r.status = pin_plain(e, w.user_request, 1'b0);
        ACT_PIN_REF:    r.status = pin_plain(e, w.user_request, 1'b1);
        ACT_PIN_DELETE: r.status = pin_for_delete(e, w.user_request, w.explicit_delete);
        ACT_DROP_CHILD: begin
          if (!e.flags.closing && !e.flags.pending && e.flags.impl && e.refc == RefOne &&
              w.parent_deletable) begin
            e.refc = '0;
            e.pin = e.pin + PinOne;
            r.answer = 1'b1;
          end else begin
            e.refc = e.refc - RefOne;
          end
        end
        ACT_REPIN: e.pin = e.pin + PinOne;
        ACT_UNPIN: begin
          e.pin = e.pin - PinOne;
          r.wake_closer = wakes(e);
        end
        ACT_ADD_REF: e.refc = e.refc + RefOne;
        ACT_DROP_REF: begin
          e.refc = e.refc - RefOne;
          r.wake_closer = wakes(e);
          r.answer = e.refc == '0;
        end
        ACT_UNPIN_DROP: begin
          e.refc = e.refc - RefOne;
          e.pin = e.pin - PinOne;
          r.wake_closer = wakes(e);
          r.answer = e.refc == '0;
        end
        ACT_CLOSE: begin
          r.answer = e.refc == '0;
          e.flags.closing = 1'b1;
        end
        default: r.answer = e.refc == '0;
      endcase
      slot_ent[w.slot] = e;
    end
    r.pin_count_out = e.pin;
    r.ref_count_out = e.refc;
    r.flags_out = {e.flags.deferred, e.flags.closing, e.flags.pending};
    return r;
  endfunction

  function automatic logic [SlotW-1:0] live_slot_pick();
    int unsigned s;
    s = $urandom_range(NumSlots - 1);
    if (live_slots == 0) return SlotW'(s);
    while (!slot_used[s]) s = (s + 1) % NumSlots;
    return SlotW'(s);
  endfunction

  function automatic req_t random_cmd();
    logic [3:0]       act;
    logic [SlotW-1:0] s;
    int unsigned      roll;
    roll = $urandom_range(99);
    if (roll >= 96) return req_t'(ReqW'($urandom));
    s = ($urandom_range(99) < 85) ? live_slot_pick() : SlotW'($urandom);
    if (roll < 7 || (live_slots < 4 && roll < 40)) act = ACT_CREATE;
    else if (roll < 11) act = ACT_REGISTER;
    else if (roll < 19) act = ACT_UNPEND;
    else if (roll < 24) act = ACT_REMOVE;
    else if (roll < 32) act = ACT_PIN;
    else if (roll < 38) act = ACT_PIN_REF;
    else if (roll < 52) act = ACT_PIN_DELETE;
    else if (roll < 58) act = ACT_DROP_CHILD;
    else if (roll < 63) act = ACT_REPIN;
    else if (roll < 71) act = ACT_UNPIN;
    else if (roll < 77) act = ACT_ADD_REF;
    else if (roll < 83) act = ACT_DROP_REF;
    else if (roll < 88) act = ACT_UNPIN_DROP;
    else if (roll < 92) act = ACT_CLOSE;
    else act = ACT_QUERY;
    if (act == ACT_CREATE && live_slots > 24) act = ACT_REMOVE;
    return cmd(act, s, 6'($urandom));
  endfunction

  task automatic report_bad(string msg);
    $display("[%0t] %s", $time, msg);
    bad_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_bad($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, want));
  endtask

  task automatic issue(req_t w, bit fixed = 1'b0, rsp_t want = '0);
    rsp_t predicted;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      req_i <= req_t'(ReqW'($urandom));
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy_o);
    predicted = apply_action(w);
    results_due.push_back(fixed ? want : predicted);
    words_sent++;
    status_seen[predicted.status]++;
    if (live_slots > peak_live) peak_live = live_slots;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (results_due.size() == 0) begin
        report_bad($sformatf("result %0d arrived with none expected", results_seen));
      end else begin
        want = results_due.pop_front();
        check_field("status", 32'(rsp_o.status), 32'(want.status));
        check_field("handle", 32'(rsp_o.handle_out), 32'(want.handle_out));
        check_field("answer", 32'(rsp_o.answer), 32'(want.answer));
        check_field("wake", 32'(rsp_o.wake_closer), 32'(want.wake_closer));
        check_field("pin count", 32'(rsp_o.pin_count_out), 32'(want.pin_count_out));
        check_field("ref count", 32'(rsp_o.ref_count_out), 32'(want.ref_count_out));
        check_field("flags", 32'(rsp_o.flags_out), 32'(want.flags_out));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("cycle limit hit, %0d results still owed", results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned idle_plan [4];
    idle_plan = '{0, 60, 19, 0};

    plan(cmd(ACT_QUERY, 8'h00, OptNone), 1'b1, rsp_of(ST_BADPAR, 8'h00, '0, '0, '0));
    plan(cmd(ACT_REMOVE, 8'hFF, OptNone), 1'b1, rsp_of(ST_BADPAR, 8'hFF, '0, '0, '0));
    plan(cmd(ACT_CREATE, 8'hFF, OptUser), 1'b1,
         rsp_of(ST_OK, 8'h00, PinOne, RefOne, FlPending));
    plan(cmd(ACT_REGISTER, 8'hFF, OptImpl | OptChild), 1'b1,
         rsp_of(ST_OK, 8'hFF, PinOne, '0, FlPending));
    plan(cmd(ACT_REGISTER, 8'h00, OptUser), 1'b1,
         rsp_of(ST_BADPAR, 8'h00, PinOne, RefOne, FlPending));
    plan(cmd(ACT_CREATE, 8'hAA, OptNone), 1'b1,
         rsp_of(ST_OK, 8'h01, PinOne, RefOne, FlPending));
    plan(cmd(ActUnused, 8'h00, OptNone), 1'b1, rsp_of(ST_BADPAR, 8'h00, '0, '0, '0));
    plan(cmd(ACT_PIN, 8'h00, OptNone));
    plan(cmd(ACT_UNPEND, 8'h00, OptNone));
    plan(cmd(ACT_UNPEND, 8'h01, OptNone));
    plan(cmd(ACT_UNPEND, 8'hFF, OptNone));
    plan(cmd(ACT_PIN, 8'h00, OptFromUser));
    plan(cmd(ACT_PIN, 8'h01, OptFromUser));
    plan(cmd(ACT_PIN_DELETE, 8'h01, OptFromUser | OptExpl));
    plan(cmd(ACT_PIN_DELETE, 8'h01, OptNone));
    plan(cmd(ACT_PIN_REF, 8'h00, OptNone));
    plan(cmd(ACT_PIN_DELETE, 8'h00, OptExpl));
    plan(cmd(ACT_PIN_DELETE, 8'h00, OptExpl));
    plan(cmd(ACT_DROP_REF, 8'h00, OptNone));
    plan(cmd(ACT_PIN_DELETE, 8'h00, OptNone));
    plan(cmd(ACT_UNPIN, 8'h00, OptNone));
    plan(cmd(ACT_UNPIN, 8'h00, OptNone));
    plan(cmd(ACT_PIN, 8'hFF, OptFromUser));
    plan(cmd(ACT_ADD_REF, 8'hFF, OptNone));
    plan(cmd(ACT_DROP_CHILD, 8'hFF, OptMayDel));
    plan(cmd(ACT_CLOSE, 8'hFF, OptNone));
    plan(cmd(ACT_UNPIN, 8'h01, OptNone));
    plan(cmd(ACT_REPIN, 8'h01, OptNone));
    plan(cmd(ACT_UNPIN_DROP, 8'h01, OptNone));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_rows[i]) issue(plan_rows[i].word, plan_rows[i].fixed, plan_rows[i].want);

    for (int p = 0; p < 4; p++) begin
      drain();
      idle_pct = idle_plan[p];
      if (p == 2) begin
        // fill the table, bounce off it, then thin it out again
        while (live_slots < NumSlots) issue(cmd(ACT_CREATE, SlotW'($urandom), 6'($urandom)));
        issue(cmd(ACT_CREATE, SlotW'($urandom), 6'($urandom)));
        issue(cmd(ACT_REGISTER, SlotW'($urandom), 6'($urandom)));
        issue(cmd(ACT_CREATE, SlotW'($urandom), 6'($urandom)));
        for (int s = 0; s < NumSlots && live_slots > 12; s++)
          if (slot_used[s] && $urandom_range(99) < 95)
            issue(cmd(ACT_REMOVE, SlotW'(s), 6'($urandom)));
      end
      repeat (300) issue(random_cmd());
    end

    drain();
    repeat (6) @(posedge clk_i);

    $display("%0d commands sent, %0d results checked, table peaked at %0d of %0d slots",
             words_sent, results_seen, peak_live, NumSlots);
    $display("status mix: ok %0d, no resources %0d, bad param %0d, deleted %0d, %s %0d, %s %0d",
             status_seen[ST_OK], status_seen[ST_NORES], status_seen[ST_BADPAR],
             status_seen[ST_DELETED], "illegal", status_seen[ST_ILLEGAL], "again",
             status_seen[ST_AGAIN]);
    if (bad_count == 0 && results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/hct_pkg.sv
hdl/hct_entry_mem.sv
hdl/hct_slot_map.sv
hdl/hct_action.sv
hdl/handle_table_refcount_lifecycle.sv
tb/sv/handle_table_refcount_lifecycle_test.sv
